// ----- rtl/fpsfm_pkg.sv -----
`timescale 1ns / 1ps

package fpsfm_pkg;

    localparam int MAX_SAMPLES = 2048;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = 12;
    localparam int DEN_W       = 2 * CNT_W;
    localparam int SUM_W       = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [15:0] STRIDE_RST    = 16'd250;
    localparam logic [7:0]  THRESHOLD_RST = 8'd20;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_EOF     = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;

    localparam logic [1:0] CFG_STRIDE    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_BELOW     = 2'd2;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_EOF,
        CMD_REFRESH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] pixel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic        fault_raised;
        logic [7:0]  mean_difference;
        logic [11:0] samples_used;
        logic        samples_dropped;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DENOM,
        ST_LIMIT,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

// ----- rtl/frame_pairwise_spread_fault_monitor.sv -----
`timescale 1ns / 1ps

// Frame spread monitor. Items are written with push/full: a pixel byte, an end of
// frame, or a refresh tick that clears the latched fault. Every sample_stride-th
// pixel of a frame is kept, starting with the first. At end of frame one result is
// made available on the empty/pop side: the floored mean absolute difference over
// all pairs of kept samples, the sample count, a dropped flag when more than 2048
// samples arrived, and a fault flag that is set only when the fault newly latches.
// The front takes one transfer every cycle while its four-entry command queue has
// room; pixels that are not kept cost nothing further. The back executes commands
// one at a time: a kept sample walks the sample store through its single read
// port, reading every stored sample once; an end of frame runs the multiply, the
// limit multiply, eight divider steps and the result load; a refresh only clears
// the latch. The result register lets the back continue while a finished
// result waits to be popped, until the next end of frame. Configuration writes are
// taken at any time but must only be made while the block is idle.

module frame_pairwise_spread_fault_monitor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  fpsfm_pkg::t_in    i_in,
    output logic              empty,
    input  logic              pop,
    output fpsfm_pkg::t_out   o_out,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    logic [15:0] r_stride;
    logic [7:0]  r_threshold;
    logic        r_below;

    logic            cmd_vld, cmd_rdy;
    fpsfm_pkg::t_cmd cmd;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= fpsfm_pkg::STRIDE_RST;
            r_threshold <= fpsfm_pkg::THRESHOLD_RST;
            r_below     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                fpsfm_pkg::CFG_STRIDE:    r_stride    <= i_cfg_data;
                fpsfm_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                fpsfm_pkg::CFG_BELOW:     r_below     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies transfers and decimates pixels by the stride.
    fpsfm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in      (i_in),
        .i_stride  (r_stride),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_rdy (cmd_rdy)
    );

    // The back owns the sample store, the pair sum, the divider and the fault latch.
    fpsfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (cmd_vld),
        .i_cmd       (cmd),
        .o_cmd_rdy   (cmd_rdy),
        .i_threshold (r_threshold),
        .i_below     (r_below),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

    // A frame never reports more samples than the store holds.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.samples_used <= 12'(fpsfm_pkg::MAX_SAMPLES)))
        else $error("samples_used exceeds capacity");

    // Samples can only be dropped once the store is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.samples_dropped) |->
            (o_out.samples_used == 12'(fpsfm_pkg::MAX_SAMPLES)))
        else $error("samples dropped before the store was full");

    // A nonzero mean needs at least one pair of samples.
    a_mean_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.mean_difference != 8'd0) |-> (o_out.samples_used >= 12'd2))
        else $error("nonzero mean with fewer than two samples");

endmodule

// ----- rtl/fpsfm_front.sv -----
`timescale 1ns / 1ps

module fpsfm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  fpsfm_pkg::t_in       i_in,
    input  logic [15:0]          i_stride,
    output logic                 o_cmd_vld,
    output fpsfm_pkg::t_cmd      o_cmd,
    input  logic                 i_cmd_rdy
);

    fpsfm_pkg::t_cmd r_q [fpsfm_pkg::QDEPTH];
    logic [fpsfm_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [fpsfm_pkg::QPTR_W:0]   r_cnt;
    logic [15:0] r_pos;
    logic [16:0] pos_inc;
    logic [16:0] stride_eff;
    logic        accept, enq, deq;
    fpsfm_pkg::t_cmd new_cmd;

    assign o_full    = (r_cnt == (fpsfm_pkg::QPTR_W+1)'(fpsfm_pkg::QDEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rptr];
    assign accept    = i_push && !o_full;
    assign deq       = o_cmd_vld && i_cmd_rdy;
    assign pos_inc   = {1'b0, r_pos} + 17'd1;
    assign stride_eff = (i_stride == 16'd0) ? 17'd1 : {1'b0, i_stride};

    always_comb begin
        new_cmd.pixel = i_in.pixel_value;
        new_cmd.kind  = fpsfm_pkg::CMD_SAMPLE;
        enq = 1'b0;
        case (i_in.req_type)
            fpsfm_pkg::REQ_PIXEL: begin
                enq = accept && (r_pos == 16'd0);
            end
            fpsfm_pkg::REQ_EOF: begin
                new_cmd.kind = fpsfm_pkg::CMD_EOF;
                enq = accept;
            end
            fpsfm_pkg::REQ_REFRESH: begin
                new_cmd.kind = fpsfm_pkg::CMD_REFRESH;
                enq = accept;
            end
            default: begin
                enq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept && i_in.req_type == fpsfm_pkg::REQ_PIXEL) begin
                r_pos <= (pos_inc >= stride_eff) ? 16'd0 : pos_inc[15:0];
            end else if (accept && i_in.req_type == fpsfm_pkg::REQ_EOF) begin
                r_pos <= '0;
            end
            if (enq) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (deq) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!enq && deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wptr] <= new_cmd;
        end
    end

endmodule

// ----- rtl/fpsfm_back.sv -----
`timescale 1ns / 1ps

module fpsfm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_vld,
    input  fpsfm_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_rdy,
    input  logic [7:0]           i_threshold,
    input  logic                 i_below,
    output logic                 o_empty,
    input  logic                 i_pop,
    output fpsfm_pkg::t_out      o_out
);

    fpsfm_pkg::t_back_state r_state, n_state;

    logic [7:0] r_mem [fpsfm_pkg::MAX_SAMPLES];
    logic [7:0] r_rdata;
    logic       r_rd_vld;
    logic [fpsfm_pkg::CNT_W-1:0] r_kept, r_idx;
    logic [fpsfm_pkg::SUM_W-1:0] r_sum, r_limit, r_rem;
    logic [fpsfm_pkg::DEN_W-1:0] r_denom;
    logic [7:0] r_pix, r_quot;
    logic [2:0] r_bit;
    logic       r_ovf, r_latched;
    logic       r_out_vld;
    fpsfm_pkg::t_out r_out;

    logic [7:0] diff;
    logic [fpsfm_pkg::SUM_W-1:0] shifted;
    logic rd_en, wr_en, walk_done, load_out, cond;
    logic [fpsfm_pkg::DEN_W-1:0] prod;

    assign o_cmd_rdy = (r_state == fpsfm_pkg::ST_IDLE);
    assign o_empty   = !r_out_vld;
    assign o_out     = r_out;

    assign diff      = (r_pix > r_rdata) ? (r_pix - r_rdata) : (r_rdata - r_pix);
    assign rd_en     = (r_state == fpsfm_pkg::ST_WALK) && (r_idx != r_kept);
    assign walk_done = (r_state == fpsfm_pkg::ST_WALK) && (r_idx == r_kept) && !r_rd_vld;
    assign wr_en     = walk_done;
    assign shifted   = fpsfm_pkg::SUM_W'(r_denom) << r_bit;
    assign load_out  = (r_state == fpsfm_pkg::ST_OUT) && (!r_out_vld || i_pop);
    assign prod      = fpsfm_pkg::DEN_W'(r_kept) * fpsfm_pkg::DEN_W'(r_kept - 1'b1);

    always_comb begin
        if (r_denom == '0) begin
            cond = i_below ? (i_threshold != 8'd0) : 1'b0;
        end else begin
            cond = i_below ? (r_sum < r_limit) : (r_sum > r_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpsfm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpsfm_pkg::ST_IDLE: begin
                if (i_cmd_vld && i_cmd.kind == fpsfm_pkg::CMD_SAMPLE &&
                    r_kept < fpsfm_pkg::CNT_W'(fpsfm_pkg::MAX_SAMPLES)) begin
                    n_state = fpsfm_pkg::ST_WALK;
                end else if (i_cmd_vld && i_cmd.kind == fpsfm_pkg::CMD_EOF) begin
                    n_state = fpsfm_pkg::ST_DENOM;
                end
            end
            fpsfm_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = fpsfm_pkg::ST_IDLE;
                end
            end
            fpsfm_pkg::ST_DENOM: n_state = fpsfm_pkg::ST_LIMIT;
            fpsfm_pkg::ST_LIMIT: n_state = fpsfm_pkg::ST_DIV;
            fpsfm_pkg::ST_DIV: begin
                if (r_bit == 3'd0) begin
                    n_state = fpsfm_pkg::ST_OUT;
                end
            end
            fpsfm_pkg::ST_OUT: begin
                if (load_out) begin
                    n_state = fpsfm_pkg::ST_IDLE;
                end
            end
            default: n_state = fpsfm_pkg::ST_IDLE;
        endcase
    end

    // Sample store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[fpsfm_pkg::ADDR_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_kept[fpsfm_pkg::ADDR_W-1:0]] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept    <= '0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
            r_latched <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld <= rd_en;
            if (r_rd_vld) begin
                r_sum <= r_sum + fpsfm_pkg::SUM_W'({diff, 1'b0});
            end
            if (wr_en) begin
                r_kept <= r_kept + 1'b1;
            end
            if (r_state == fpsfm_pkg::ST_IDLE && i_cmd_vld) begin
                if (i_cmd.kind == fpsfm_pkg::CMD_SAMPLE &&
                    r_kept >= fpsfm_pkg::CNT_W'(fpsfm_pkg::MAX_SAMPLES)) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.kind == fpsfm_pkg::CMD_REFRESH) begin
                    r_latched <= 1'b0;
                end
            end
            if (load_out) begin
                if (cond) begin
                    r_latched <= 1'b1;
                end
                r_kept <= '0;
                r_sum  <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fpsfm_pkg::ST_IDLE) begin
            r_pix <= i_cmd.pixel;
            r_idx <= '0;
        end else if (rd_en) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == fpsfm_pkg::ST_DENOM) begin
            r_denom <= (r_kept >= fpsfm_pkg::CNT_W'(2)) ? prod : '0;
        end
        if (r_state == fpsfm_pkg::ST_LIMIT) begin
            r_limit <= fpsfm_pkg::SUM_W'(r_denom) * fpsfm_pkg::SUM_W'(i_threshold);
            r_rem   <= r_sum;
            r_quot  <= '0;
            r_bit   <= 3'd7;
        end
        if (r_state == fpsfm_pkg::ST_DIV) begin
            if (r_rem >= shifted) begin
                r_rem         <= r_rem - shifted;
                r_quot[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (load_out) begin
            r_out.fault_raised    <= cond && !r_latched;
            r_out.mean_difference <= (r_denom == '0) ? 8'd0 : r_quot;
            r_out.samples_used    <= r_kept;
            r_out.samples_dropped <= r_ovf;
        end
    end

endmodule
